// ===== design/mersenne_twister_generator_top_assert.svh =====
// assertion macros for the mt19937 generator
// used by mersenne_twister_generator_top, expects clk_i and rst_ni in scope
`ifndef MERSENNE_TWISTER_GENERATOR_TOP_ASSERT_SVH
`define MERSENNE_TWISTER_GENERATOR_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define MTG_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define MTG_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/mtg_pkg.sv =====
// shared types, constants and functions of the mt19937 generator
// no dependencies
package mtg_pkg;

  typedef enum logic [1:0] {
    OP_SEED,
    OP_WORD,
    OP_FRAC,
    OP_NONE
  } op_e;

  typedef enum logic [1:0] {
    KIND_SEED = 2'd0,
    KIND_WORD = 2'd1,
    KIND_FRAC = 2'd2
  } kind_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] key;
  } cmd_t;

  typedef struct packed {
    logic seeding;
    logic twisting;
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL0,
    ST_FILL_MUL,
    ST_FILL_WR,
    ST_MIX_RD,
    ST_MIX_WR,
    ST_MIX_WRAP,
    ST_TOP,
    ST_DRAW,
    ST_DRAW_WAIT,
    ST_TW_START,
    ST_TW_LOAD,
    ST_TW_RD_NXT,
    ST_TW_RD_FAR,
    ST_TW_WR,
    ST_OUT
  } state_e;

  localparam logic [31:0] SEED_INIT = 32'd19650218;
  localparam logic [31:0] MULT_FILL = 32'd1812433253;
  localparam logic [31:0] MULT_MIX1 = 32'd1664525;
  localparam logic [31:0] MULT_MIX2 = 32'd1566083941;
  localparam logic [31:0] TWIST_XOR = 32'h9908b0df;
  localparam logic [31:0] TOP_BIT   = 32'h80000000;
  localparam logic [31:0] TEMPER_B  = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C  = 32'hefc60000;
  localparam int unsigned VALUE_W   = 53;

  function automatic logic [31:0] mix_back(input logic [31:0] w);
    return w ^ (w >> 30);
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== design/mtg_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module mtg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/mtg_front.sv =====
// input stage: takes stream items and turns the kind into an operation
// depends on mtg_pkg
module mtg_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    kind_i,
  input  logic [31:0]   seed_word_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output mtg_pkg::cmd_t cmd_o
);

  logic          valid_q, valid_d;
  mtg_pkg::cmd_t cmd_q, cmd_d;
  mtg_pkg::op_e  op;

  always_comb begin
    case (kind_i)
      mtg_pkg::KIND_SEED: op = mtg_pkg::OP_SEED;
      mtg_pkg::KIND_WORD: op = mtg_pkg::OP_WORD;
      mtg_pkg::KIND_FRAC: op = mtg_pkg::OP_FRAC;
      default:            op = mtg_pkg::OP_NONE;
    endcase
  end

  assign in_ready_o = !valid_q || cmd_ready_i;

  always_comb begin
    valid_d = valid_q && !cmd_ready_i;
    cmd_d   = cmd_q;
    if (in_valid_i && in_ready_o) begin
      valid_d    = 1'b1;
      cmd_d.op   = op;
      cmd_d.key  = seed_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

// ===== design/mtg_queue.sv =====
// two-entry command queue between front and back
// depends on mtg_pkg
module mtg_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  mtg_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output mtg_pkg::cmd_t pop_cmd_o,
  output logic [1:0]    count_o
);

  mtg_pkg::cmd_t slot_q [2];
  logic          wr_q, wr_d, rd_q, rd_d;
  logic [1:0]    count_q, count_d;
  logic          push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = slot_q[rd_q];
  assign count_o      = count_q;

  always_comb begin
    wr_d    = push ? !wr_q : wr_q;
    rd_d    = pop ? !rd_q : rd_q;
    count_d = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== design/mtg_back.sv =====
// execution engine: seeding passes, twist and tempered draws over the table ram
// depends on mtg_pkg and mtg_ram
module mtg_back #(
  parameter int unsigned TABLE_WORDS    = 624,
  parameter int unsigned SHIFT_DISTANCE = 397
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  mtg_pkg::cmd_t                 cmd_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mtg_pkg::VALUE_W-1:0]   out_value_o,
  output mtg_pkg::status_t              stat_o
);

  localparam int unsigned AW = $clog2(TABLE_WORDS);
  localparam int unsigned PW = $clog2(TABLE_WORDS + 1);
  localparam logic [AW-1:0] LAST    = AW'(TABLE_WORDS - 1);
  localparam logic [PW-1:0] POS_END = PW'(TABLE_WORDS);
  localparam logic [AW:0]   FAR_OFS = (AW + 1)'(SHIFT_DISTANCE);
  localparam logic [AW:0]   WORDS_X = (AW + 1)'(TABLE_WORDS);

  mtg_pkg::state_e state_q, state_d;
  mtg_pkg::op_e    op_q, op_d;
  logic [AW-1:0]   n_q, n_d;
  logic [PW-1:0]   cnt_q, cnt_d;
  logic [PW-1:0]   pos_q, pos_d;
  logic            pass_q, pass_d;
  logic            half_q, half_d;
  logic            emit_q, emit_d;
  logic [31:0]     key_q, key_d;
  logic [31:0]     prev_q, prev_d;
  logic [31:0]     prod_q, prod_d;
  logic [31:0]     cur_q, cur_d;
  logic [31:0]     nxt_q, nxt_d;
  logic [26:0]     acc_q, acc_d;
  logic [mtg_pkg::VALUE_W-1:0] res_q, res_d, oval_q, oval_d;
  logic            ovalid_q, ovalid_d;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [31:0]     wdata, rdata;
  logic [31:0]     val, y, tw, tmp;
  logic [AW:0]     far_sum, far_wrap;
  logic [AW-1:0]   nxt_idx, far_idx;

  mtg_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    nxt_idx  = (n_q == LAST) ? '0 : n_q + AW'(1);
    far_sum  = {1'b0, n_q} + FAR_OFS;
    far_wrap = (far_sum >= WORDS_X) ? far_sum - WORDS_X : far_sum;
    far_idx  = far_wrap[AW-1:0];
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    n_d      = n_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    pass_d   = pass_q;
    half_d   = half_q;
    emit_d   = emit_q;
    key_d    = key_q;
    prev_d   = prev_q;
    prod_d   = prod_q;
    cur_d    = cur_q;
    nxt_d    = nxt_q;
    acc_d    = acc_q;
    res_d    = res_q;
    oval_d   = oval_q;
    ovalid_d = ovalid_q && !out_ready_i;
    cmd_ready_o = 1'b0;
    we       = 1'b0;
    waddr    = n_q;
    wdata    = '0;
    raddr    = n_q;
    val      = '0;
    y        = '0;
    tw       = '0;
    tmp      = rdata ^ prod_q;
    case (state_q)
      mtg_pkg::ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          op_d   = cmd_i.op;
          half_d = 1'b0;
          case (cmd_i.op)
            mtg_pkg::OP_SEED: begin
              key_d   = cmd_i.key;
              emit_d  = 1'b1;
              state_d = mtg_pkg::ST_FILL0;
            end
            mtg_pkg::OP_WORD, mtg_pkg::OP_FRAC: state_d = mtg_pkg::ST_DRAW;
            default: begin
              res_d   = '0;
              state_d = mtg_pkg::ST_OUT;
            end
          endcase
        end
      end
      mtg_pkg::ST_FILL0: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = mtg_pkg::SEED_INIT;
        prev_d  = mtg_pkg::SEED_INIT;
        n_d     = AW'(1);
        state_d = mtg_pkg::ST_FILL_MUL;
      end
      mtg_pkg::ST_FILL_MUL: begin
        prod_d  = 32'(mtg_pkg::mix_back(prev_q) * mtg_pkg::MULT_FILL);
        state_d = mtg_pkg::ST_FILL_WR;
      end
      mtg_pkg::ST_FILL_WR: begin
        val    = prod_q + 32'(n_q);
        we     = 1'b1;
        wdata  = val;
        prev_d = val;
        if (n_q == LAST) begin
          prev_d  = mtg_pkg::SEED_INIT;
          n_d     = AW'(1);
          cnt_d   = POS_END;
          pass_d  = 1'b0;
          state_d = mtg_pkg::ST_MIX_RD;
        end else begin
          n_d     = n_q + AW'(1);
          state_d = mtg_pkg::ST_FILL_MUL;
        end
      end
      mtg_pkg::ST_MIX_RD: begin
        prod_d  = 32'(mtg_pkg::mix_back(prev_q) *
                      (pass_q ? mtg_pkg::MULT_MIX2 : mtg_pkg::MULT_MIX1));
        state_d = mtg_pkg::ST_MIX_WR;
      end
      mtg_pkg::ST_MIX_WR: begin
        val    = pass_q ? tmp - 32'(n_q) : tmp + key_q;
        we     = 1'b1;
        wdata  = val;
        prev_d = val;
        cnt_d  = cnt_q - PW'(1);
        if (n_q == LAST) begin
          state_d = mtg_pkg::ST_MIX_WRAP;
        end else begin
          n_d = n_q + AW'(1);
          if (cnt_q == PW'(1)) begin
            if (!pass_q) begin
              pass_d  = 1'b1;
              cnt_d   = PW'(TABLE_WORDS - 1);
              state_d = mtg_pkg::ST_MIX_RD;
            end else begin
              state_d = mtg_pkg::ST_TOP;
            end
          end else begin
            state_d = mtg_pkg::ST_MIX_RD;
          end
        end
      end
      mtg_pkg::ST_MIX_WRAP: begin
        we    = 1'b1;
        waddr = '0;
        wdata = prev_q;
        n_d   = AW'(1);
        if (cnt_q == '0) begin
          if (!pass_q) begin
            pass_d  = 1'b1;
            cnt_d   = PW'(TABLE_WORDS - 1);
            state_d = mtg_pkg::ST_MIX_RD;
          end else begin
            state_d = mtg_pkg::ST_TOP;
          end
        end else begin
          state_d = mtg_pkg::ST_MIX_RD;
        end
      end
      mtg_pkg::ST_TOP: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = mtg_pkg::TOP_BIT;
        pos_d   = POS_END;
        res_d   = '0;
        state_d = emit_q ? mtg_pkg::ST_OUT : mtg_pkg::ST_IDLE;
      end
      mtg_pkg::ST_DRAW: begin
        raddr = pos_q[AW-1:0];
        if (pos_q >= POS_END) begin
          n_d     = '0;
          state_d = mtg_pkg::ST_TW_START;
        end else begin
          state_d = mtg_pkg::ST_DRAW_WAIT;
        end
      end
      mtg_pkg::ST_DRAW_WAIT: begin
        y     = mtg_pkg::temper(rdata);
        pos_d = pos_q + PW'(1);
        if (op_q == mtg_pkg::OP_FRAC && !half_q) begin
          acc_d   = y[31:5];
          half_d  = 1'b1;
          state_d = mtg_pkg::ST_DRAW;
        end else begin
          res_d   = (op_q == mtg_pkg::OP_FRAC) ? {acc_q, y[31:6]}
                                               : {21'd0, y};
          state_d = mtg_pkg::ST_OUT;
        end
      end
      mtg_pkg::ST_TW_START: begin
        raddr   = '0;
        state_d = mtg_pkg::ST_TW_LOAD;
      end
      mtg_pkg::ST_TW_LOAD: begin
        cur_d   = rdata;
        state_d = mtg_pkg::ST_TW_RD_NXT;
      end
      mtg_pkg::ST_TW_RD_NXT: begin
        raddr   = nxt_idx;
        state_d = mtg_pkg::ST_TW_RD_FAR;
      end
      mtg_pkg::ST_TW_RD_FAR: begin
        raddr   = far_idx;
        nxt_d   = rdata;
        state_d = mtg_pkg::ST_TW_WR;
      end
      mtg_pkg::ST_TW_WR: begin
        y     = {cur_q[31], nxt_q[30:0]};
        tw    = rdata ^ (y >> 1) ^ (y[0] ? mtg_pkg::TWIST_XOR : 32'd0);
        we    = 1'b1;
        wdata = tw;
        cur_d = nxt_q;
        if (n_q == LAST) begin
          pos_d   = '0;
          state_d = mtg_pkg::ST_DRAW;
        end else begin
          n_d     = n_q + AW'(1);
          state_d = mtg_pkg::ST_TW_RD_NXT;
        end
      end
      mtg_pkg::ST_OUT: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          oval_d   = res_q;
          state_d  = mtg_pkg::ST_IDLE;
        end
      end
      default: state_d = mtg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mtg_pkg::ST_FILL0;
      pos_q    <= POS_END;
      emit_q   <= 1'b0;
      key_q    <= '0;
      ovalid_q <= 1'b0;
      pass_q   <= 1'b0;
      half_q   <= 1'b0;
      n_q      <= '0;
      cnt_q    <= '0;
      op_q     <= mtg_pkg::OP_NONE;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      emit_q   <= emit_d;
      key_q    <= key_d;
      ovalid_q <= ovalid_d;
      pass_q   <= pass_d;
      half_q   <= half_d;
      n_q      <= n_d;
      cnt_q    <= cnt_d;
      op_q     <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    prod_q <= prod_d;
    cur_q  <= cur_d;
    nxt_q  <= nxt_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
    oval_q <= oval_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_value_o = oval_q;

  always_comb begin
    stat_o.seeding  = (state_q == mtg_pkg::ST_FILL0) || (state_q == mtg_pkg::ST_FILL_MUL) ||
                      (state_q == mtg_pkg::ST_FILL_WR) || (state_q == mtg_pkg::ST_MIX_RD) ||
                      (state_q == mtg_pkg::ST_MIX_WR) || (state_q == mtg_pkg::ST_MIX_WRAP);
    stat_o.twisting = (state_q == mtg_pkg::ST_TW_START) || (state_q == mtg_pkg::ST_TW_LOAD) ||
                      (state_q == mtg_pkg::ST_TW_RD_NXT) || (state_q == mtg_pkg::ST_TW_RD_FAR) ||
                      (state_q == mtg_pkg::ST_TW_WR);
  end

endmodule

// ===== design/mersenne_twister_generator_top.sv =====
// MT19937 generator with a one-word seed key. After reset, and for every seed item, the
// engine rebuilds the 624-word table (fill, then two mixing passes over a table ram with
// one write port and one read port) and takes no item meanwhile. The twist runs once all
// table words have been drawn, also before the first draw after seeding, and is bound by
// the single ram read port.
// depends on mtg_pkg, mtg_front, mtg_queue, mtg_back and the assertion macro header
`include "mersenne_twister_generator_top_assert.svh"

module mersenne_twister_generator_top #(
  parameter int unsigned TABLE_WORDS    = 624,
  parameter int unsigned SHIFT_DISTANCE = 397
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // seed_word
  input  logic [1:0]  s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // value, zero padding
);

  logic             f_valid, f_ready, q_valid, q_ready;
  mtg_pkg::cmd_t    f_cmd, q_cmd;
  logic [1:0]       q_count;
  logic [mtg_pkg::VALUE_W-1:0] value;
  mtg_pkg::status_t stat;

  mtg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .kind_i      (s_axis_tuser),
    .seed_word_i (s_axis_tdata),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  mtg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_cmd_i   (f_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_cmd_o    (q_cmd),
    .count_o      (q_count)
  );

  mtg_back #(
    .TABLE_WORDS    (TABLE_WORDS),
    .SHIFT_DISTANCE (SHIFT_DISTANCE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (value),
    .stat_o      (stat)
  );

  assign m_axis_tdata = {3'd0, value};

  `MTG_ASSERT_ALWAYS(a_queue_depth, q_count <= 2'd2, "command queue over depth")
  `MTG_ASSERT_ALWAYS(a_phase_excl, !(stat.seeding && stat.twisting), "seed and twist overlap")
  `MTG_ASSERT_IMPLY(a_no_take_busy, stat.seeding || stat.twisting, !q_ready,
                    "engine took a command while busy")

endmodule
